@@ design/fstm_pkg.sv @@
`default_nettype none

package fstm_pkg;

	localparam int unsigned TEX_SIDE_BITS = 6;
	localparam int unsigned TEX_ADDR_W    = 2 * TEX_SIDE_BITS;
	localparam int unsigned TEX_DEPTH     = 1 << TEX_ADDR_W;
	localparam int unsigned SHADE_W       = 8;
	localparam int unsigned SHADE_DEPTH   = 1 << SHADE_W;
	localparam int unsigned TEXEL_W       = 8;
	localparam int unsigned POS_W         = 32;
	localparam int unsigned HALF_W        = POS_W / 2;

	localparam int unsigned S_TDATA_W = 160;
	localparam int unsigned M_TDATA_W = 24;
	localparam int unsigned PADDR_W   = 3;

	localparam logic [PADDR_W-1:0] ADDR_LOW_DETAIL = 3'd0;

	typedef enum logic [1:0] {
		REQ_WRITE_TEXEL = 2'd0,
		REQ_WRITE_SHADE = 2'd1,
		REQ_START       = 2'd2,
		REQ_DRAW        = 2'd3
	} req_type_t;

	// 16.16 u and v folded into 6.10 u (top half) and 6.10 v (bottom half)
	function automatic logic [POS_W-1:0] pack_pair(input logic [POS_W-1:0] u,
			input logic [POS_W-1:0] v);
		pack_pair = {u[HALF_W+TEX_SIDE_BITS-1:TEX_SIDE_BITS],
			v[HALF_W+TEX_SIDE_BITS-1:TEX_SIDE_BITS]};
	endfunction

	// texel address v*64+u from the integer bits of each half
	function automatic logic [TEX_ADDR_W-1:0] texel_spot(input logic [POS_W-1:0] pos);
		texel_spot = {pos[HALF_W-1:HALF_W-TEX_SIDE_BITS], pos[POS_W-1:POS_W-TEX_SIDE_BITS]};
	endfunction

endpackage

`default_nettype wire

@@ design/flat_span_texture_mapper_unit.sv @@
`default_nettype none
// Channel   Dir  Transaction                 Payload
// s_*       in   write texel/shade, start,   tuser req_type, tdata fields, tlast span_final
//                draw
// m_*       out  one pixel                   tdata color/index, tuser span_done, tlast run_last
// apb       in   register access             low_detail at 0x0
//
// A draw is accepted every cycle while s_tready is high; its pixel passes the texture read and
// then the shade read, each registered, before it is presented on m_*.
// With low_detail set each draw gives two pixels, and the draw behind it cannot move on from
// the texture-read register until the second pixel is taken. Write and start give no pixel.
// Reset clears the position, step and low_detail; the stores hold no reset.
// m_tready low stalls the whole pipe once the output and the stage before it are full.

module flat_span_texture_mapper_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	// texel_addr[11:0], shade_index[19:12], entry_value[27:20], x_frac[59:28],
	// y_frac[91:60], x_step[123:92], y_step[155:124], zero pad
	input  wire  [fstm_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire  [1:0]                     s_tuser,   // req_type
	input  wire                            s_tlast,   // span_final
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// pixel_color[7:0], texel_index[19:8], zero pad
	output logic [fstm_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tuser,   // span_done
	output logic                           m_tlast,   // run_last
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [fstm_pkg::PADDR_W-1:0]   paddr,
	input  wire  [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import fstm_pkg::*;

	logic [TEXEL_W-1:0] tex_mem [TEX_DEPTH];
	logic [TEXEL_W-1:0] shade_mem [SHADE_DEPTH];

	logic                  low_detail_q;
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      step_q;
	logic                  valid_s1, valid_s2, rep_q;
	logic [TEXEL_W-1:0]    tex_s1;
	logic [TEX_ADDR_W-1:0] spot_s1, spot_s2;
	logic                  fin_s1, fin_s2;
	logic [TEXEL_W-1:0]    color_s2;

	req_type_t             req;
	logic [TEX_ADDR_W-1:0] in_texel_addr;
	logic [SHADE_W-1:0]    in_shade_index;
	logic [TEXEL_W-1:0]    in_entry_value;
	logic [POS_W-1:0]      in_x_frac, in_y_frac, in_x_step, in_y_step;
	logic                  accept, draw_acc;
	logic                  out_last, s2_free, s1_free, adv_s1;
	logic                  cfg_wr;

	assign req            = req_type_t'(s_tuser);
	assign in_texel_addr  = s_tdata[11:0];
	assign in_shade_index = s_tdata[19:12];
	assign in_entry_value = s_tdata[27:20];
	assign in_x_frac      = s_tdata[59:28];
	assign in_y_frac      = s_tdata[91:60];
	assign in_x_step      = s_tdata[123:92];
	assign in_y_step      = s_tdata[155:124];

	// second copy of a low-detail pixel is the last one of the draw
	assign out_last = !low_detail_q || rep_q;
	assign s2_free  = !valid_s2 || (m_tready && out_last);
	assign s1_free  = !valid_s1 || s2_free;
	assign adv_s1   = valid_s1 && s2_free;
	assign s_tready = s1_free;
	assign accept   = s_tvalid && s_tready;
	assign draw_acc = accept && (req == REQ_DRAW);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_TDATA_W-TEX_ADDR_W-TEXEL_W){1'b0}}, spot_s2, color_s2};
	assign m_tuser  = fin_s2;
	assign m_tlast  = out_last;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_LOW_DETAIL);

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_LOW_DETAIL) begin
			prdata = {31'd0, low_detail_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_detail_q <= 1'b0;
			pos_q        <= '0;
			step_q       <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			rep_q        <= 1'b0;
		end else begin
			if (cfg_wr) begin
				low_detail_q <= pwdata[0];
			end
			if (accept && req == REQ_START) begin
				pos_q  <= pack_pair(in_x_frac, in_y_frac);
				step_q <= pack_pair(in_x_step, in_y_step);
			end else if (draw_acc) begin
				pos_q <= pos_q + step_q;
			end
			if (s1_free) begin
				valid_s1 <= draw_acc;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
				rep_q    <= 1'b0;
			end else if (m_tready) begin
				rep_q <= 1'b1;
			end
		end
	end

	// stores: writes land at accept, reads follow in transaction order
	always_ff @(posedge clk) begin
		if (accept && req == REQ_WRITE_TEXEL) begin
			tex_mem[in_texel_addr] <= in_entry_value;
		end
		if (draw_acc) begin
			tex_s1  <= tex_mem[texel_spot(pos_q)];
			spot_s1 <= texel_spot(pos_q);
			fin_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req == REQ_WRITE_SHADE) begin
			shade_mem[in_shade_index] <= in_entry_value;
		end
		if (adv_s1) begin
			color_s2 <= shade_mem[tex_s1];
			spot_s2  <= spot_s1;
			fin_s2   <= fin_s1;
		end
	end

endmodule

`default_nettype wire

@@ design/fstm_checker.sv @@
`default_nettype none

module fstm_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_tready,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire [fstm_pkg::M_TDATA_W-1:0] m_tdata,
	input wire                          m_tlast,
	input wire                          psel,
	input wire                          penable,
	input wire                          pwrite,
	input wire [fstm_pkg::PADDR_W-1:0]  paddr,
	input wire [31:0]                   pwdata,
	input wire [31:0]                   prdata
);
	import fstm_pkg::*;

	// input side only backs up behind a held pixel
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pixel pending");

	// first copy of a doubled pixel is followed by its twin
	a_twin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast && $stable(m_tdata)))
		else $error("low-detail repeat missing or changed");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr == ADDR_LOW_DETAIL) |=>
		(paddr != ADDR_LOW_DETAIL || prdata == {31'd0, $past(pwdata[0])}))
		else $error("low_detail readback mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled pixel dropped or changed");

endmodule

bind flat_span_texture_mapper_unit fstm_checker u_fstm_checker (.*);

`default_nettype wire

@@ test/flat_span_texture_mapper_unit_test.sv @@
module flat_span_texture_mapper_unit_test;
	import fstm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		req_type_t             kind;
		logic [TEX_ADDR_W-1:0] texel_addr;
		logic [SHADE_W-1:0]    shade_index;
		logic [7:0]            entry_value;
		logic [POS_W-1:0]      x_frac;
		logic [POS_W-1:0]      y_frac;
		logic [POS_W-1:0]      x_step;
		logic [POS_W-1:0]      y_step;
		logic                  span_final;
	} span_req_t;

	typedef struct {
		logic [7:0]            color;
		logic [TEX_ADDR_W-1:0] index;
		logic                  done;
		logic                  last;
	} pixel_t;

	class pixel_scoreboard;
		logic [TEXEL_W-1:0] texels [TEX_DEPTH];
		logic [7:0]         shades [SHADE_DEPTH];
		bit                 texel_loaded [TEX_DEPTH];
		bit                 shade_loaded [SHADE_DEPTH];
		logic [POS_W-1:0]   uv_pos;
		logic [POS_W-1:0]   uv_step;
		bit                 low_detail;
		pixel_t             pixels_due [$];
		int                 failures;

		function new();
			uv_pos     = '0;
			uv_step    = '0;
			low_detail = 1'b0;
			failures   = 0;
		endfunction

		// v integer bits (15:10) select the row, u integer bits (31:26) the column
		function logic [TEX_ADDR_W-1:0] spot_of(input logic [POS_W-1:0] pos);
			return {pos[15:10], pos[31:26]};
		endfunction

		// 16.16 u and v -> 6.10 u in the upper half, 6.10 v in the lower half
		function logic [POS_W-1:0] fold_uv(input logic [POS_W-1:0] u, input logic [POS_W-1:0] v);
			return {u[21:6], v[21:6]};
		endfunction

		function int pending();
			return pixels_due.size();
		endfunction

		function void note_input(input span_req_t it);
			pixel_t px;
			int     reps;
			case (it.kind)
			REQ_WRITE_TEXEL: begin
				texels[it.texel_addr]       = it.entry_value;
				texel_loaded[it.texel_addr] = 1'b1;
			end
			REQ_WRITE_SHADE: begin
				shades[it.shade_index]       = it.entry_value;
				shade_loaded[it.shade_index] = 1'b1;
			end
			REQ_START: begin
				uv_pos  = fold_uv(it.x_frac, it.y_frac);
				uv_step = fold_uv(it.x_step, it.y_step);
			end
			REQ_DRAW: begin
				px.index = spot_of(uv_pos);
				px.color = shades[texels[px.index]];
				px.done  = it.span_final;
				reps     = low_detail ? 2 : 1;
				for (int k = 0; k < reps; k++) begin
					px.last = (k == reps - 1);
					pixels_due.push_back(px);
				end
				// plain 32-bit add: v carries into u, carry out of u is dropped
				uv_pos = uv_pos + uv_step;
			end
			default: begin
			end
			endcase
		endfunction

		function void check_pixel(input logic [M_TDATA_W-1:0] data, input logic done,
				input logic last);
			pixel_t px;
			if (pixels_due.size() == 0) begin
				$error("unexpected pixel transaction: tdata %h", data);
				failures++;
				return;
			end
			px = pixels_due.pop_front();
			if (data[7:0] !== px.color) begin
				$error("pixel_color expected %0d got %0d", px.color, data[7:0]);
				failures++;
			end
			if (data[19:8] !== px.index) begin
				$error("texel_index expected %0d got %0d", px.index, data[19:8]);
				failures++;
			end
			if (done !== px.done) begin
				$error("span_done expected %0d got %0d", px.done, done);
				failures++;
			end
			if (last !== px.last) begin
				$error("run_last expected %0d got %0d", px.last, last);
				failures++;
			end
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [1:0]           s_tuser  = '0;
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [31:0]          pwdata   = '0;
	logic [31:0]          prdata;
	logic                 pready;

	pixel_scoreboard sb;
	bit              src_steady  = 1'b0;
	bit              sink_steady = 1'b0;
	int              items_sent  = 0;
	int              cycle_count = 0;

	flat_span_texture_mapper_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic span_req_t noise_item(input req_type_t kind);
		span_req_t it;
		it.kind        = kind;
		it.texel_addr  = TEX_ADDR_W'($urandom);
		it.shade_index = SHADE_W'($urandom);
		it.entry_value = 8'($urandom);
		it.x_frac      = $urandom;
		it.y_frac      = $urandom;
		it.x_step      = $urandom;
		it.y_step      = $urandom;
		it.span_final  = 1'($urandom);
		return it;
	endfunction

	function automatic logic [POS_W-1:0] pick_step();
		int unsigned mode;
		mode = $urandom_range(0, 3);
		case (mode)
		0: begin
			return $urandom;
		end
		1: begin
			return $urandom_range(0, 32'h0002_0000);
		end
		2: begin
			return -$urandom_range(0, 32'h0002_0000);
		end
		default: begin
			return '0;
		end
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the transaction is taken
	task automatic push_item(input span_req_t it);
		int gap;
		if ($urandom_range(0, 19) == 0)
			src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tlast  <= it.span_final;
		s_tdata  <= S_TDATA_W'({it.y_step, it.x_step, it.y_frac, it.x_frac,
			it.entry_value, it.shade_index, it.texel_addr});
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_input(it);
		items_sent++;
	endtask

	task automatic send_texel(input logic [TEX_ADDR_W-1:0] addr, input logic [7:0] value);
		span_req_t it;
		it             = noise_item(REQ_WRITE_TEXEL);
		it.texel_addr  = addr;
		it.entry_value = value;
		push_item(it);
	endtask

	task automatic send_shade(input logic [SHADE_W-1:0] idx, input logic [7:0] value);
		span_req_t it;
		it             = noise_item(REQ_WRITE_SHADE);
		it.shade_index = idx;
		it.entry_value = value;
		push_item(it);
	endtask

	task automatic send_start(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [POS_W-1:0] dx, input logic [POS_W-1:0] dy);
		span_req_t it;
		it        = noise_item(REQ_START);
		it.x_frac = x;
		it.y_frac = y;
		it.x_step = dx;
		it.y_step = dy;
		push_item(it);
	endtask

	// loads the texel and shade entry the draw will read if they are still unwritten
	task automatic draw_pixel(input logic fin);
		logic [TEX_ADDR_W-1:0] spot;
		span_req_t             it;
		spot = sb.spot_of(sb.uv_pos);
		if (!sb.texel_loaded[spot])
			send_texel(spot, 8'($urandom));
		if (!sb.shade_loaded[sb.texels[spot]])
			send_shade(sb.texels[spot], 8'($urandom));
		it            = noise_item(REQ_DRAW);
		it.span_final = fin;
		push_item(it);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// register write with junk in the unused bits, then read back
	task automatic set_low_detail(input bit ld);
		logic [31:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_LOW_DETAIL;
		pwdata  <= (32'($urandom) & 32'hffff_fffe) | 32'(ld);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.low_detail = ld;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== 32'(ld)) begin
			$error("low_detail expected %0d got %0d", ld, rd);
			sb.failures++;
		end
	endtask

	task automatic directed_items();
		send_texel(12'hfff, 8'hff);
		send_texel(12'h000, 8'h00);
		send_shade(8'hff, 8'hff);
		send_shade(8'h00, 8'h00);
		// no start yet: position and step are still zero
		draw_pixel(1'b0);
		draw_pixel(1'b1);
		// all-ones position and step: steps back by one lsb per pixel
		send_start(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		draw_pixel(1'b0);
		draw_pixel(1'b1);
		// one texel diagonally per pixel, then draws past the end of the span
		send_start(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
		repeat (3) draw_pixel(1'b0);
		draw_pixel(1'b1);
		draw_pixel(1'b0);
		draw_pixel(1'b0);
		// v half at its maximum with a one-lsb v step: carry runs into u
		send_start(32'h0, 32'h003f_ffc0, 32'h0, 32'h0000_0040);
		draw_pixel(1'b0);
		draw_pixel(1'b1);
	endtask

	task automatic random_phase(input int count);
		int first;
		int pick;
		first = items_sent;
		while (items_sent - first < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				send_texel(TEX_ADDR_W'($urandom), 8'($urandom));
			else if (pick < 14)
				send_shade(SHADE_W'($urandom), 8'($urandom));
			else if (pick < 24)
				send_start($urandom, $urandom, pick_step(), pick_step());
			else
				draw_pixel($urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 19) == 0)
				sink_steady = !sink_steady;
			stall = sink_steady ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			sb.check_pixel(m_tdata, m_tuser, m_tlast);
		end
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_low_detail(1'b0);
		directed_items();
		for (int phase = 0; phase < 4; phase++) begin
			drain();
			set_low_detail(!phase[0]);
			random_phase(160);
		end
		drain();
		if (sb.failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/fstm_pkg.sv
design/flat_span_texture_mapper_unit.sv
design/fstm_checker.sv
test/flat_span_texture_mapper_unit_test.sv
